FILE: sv/assert_macros.svh
// Assertion macros shared by the converter RTL.
// Included by modules that check their own pipeline; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked property, disabled while reset is asserted.
`define ACC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Checked property, evaluated during reset as well.
`define ACC_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ACC_ASSERT(label, clk, rst_n, prop)
`define ACC_ASSERT_NORST(label, clk, prop)
`endif
`endif

FILE: sv/acc_pkg.sv
// Constants, types and helper functions of the ADC channel converter.
// Used by adc_channel_converter_top; no dependencies.
package acc_pkg;

  localparam int CH_W    = 5;
  localparam int RAW_W   = 16;
  localparam int GAIN_W  = 7;
  localparam int OUT_W   = 16;
  localparam int MAG_W   = 16;
  localparam int PROD_W  = 28;
  localparam int MVQ_W   = 13;
  localparam int MV_SHIFT = 15;
  localparam int MV_W    = 14;
  localparam int TN_W    = 25;
  localparam int TMAG_W  = 23;
  localparam int TPROD_W = 46;
  localparam int RECIP_SHIFT = 32;
  localparam int TQ_W    = 14;
  localparam int TEMP_W  = 15;

  localparam int MV_RANGE    = 4900;
  localparam int TEMP_OFFSET = 153925;
  localparam int TEMP_SLOPE  = 563;
  localparam int TEMP_SCALE  = 1000;
  // floor(2^32 / 563): quotient estimate is exact or one low for inputs below 2^23
  localparam longint TEMP_RECIP = 64'd7628716;
  localparam int GAIN_DIV    = 30720;
  localparam int THIRD_MUL   = 43;
  localparam int THIRD_SHIFT = 7;
  localparam int SUPPLY_SHIFT = 10;

  localparam logic [CH_W-1:0]   CH_MV_FIRST = 5'd0;
  localparam logic [CH_W-1:0]   CH_MV_LAST  = 5'd23;
  localparam logic [CH_W-1:0]   CH_RAW      = 5'd24;
  localparam logic [CH_W-1:0]   CH_SUPPLY   = 5'd25;
  localparam logic [CH_W-1:0]   CH_TEMP     = 5'd26;
  localparam logic [CH_W-1:0]   CH_GAIN     = 5'd27;
  localparam logic [CH_W-1:0]   CH_REF      = 5'd28;
  localparam logic [GAIN_W-1:0] GAIN_RESET  = 7'd1;

  // Pipeline stage positions
  localparam int STG_A = 0;
  localparam int STG_B = 1;
  localparam int STG_C = 2;
  localparam int STG_D = 3;
  localparam int STG_E = 4;
  localparam int STG_F = 5;
  localparam int STG_G = 6;
  localparam int STG_H = 7;
  localparam int STG_I = 8;
  localparam int STG_O = 9;
  localparam int NSTG  = 10;
  localparam int NDIV  = 3;

  typedef struct packed {
    logic [CH_W-1:0]         ch;
    logic                    neg;
    logic signed [OUT_W-1:0] side;
    logic [GAIN_W-1:0]       g;
    logic [MVQ_W-1:0]        num;
    logic [MVQ_W-1:0]        quo;
    logic [GAIN_W-1:0]       rem;
  } div_stage_t;

  // Restoring division over quotient bits hi down to lo.
  function automatic div_stage_t div_bits(div_stage_t in, int hi, int lo);
    div_stage_t         o;
    logic [GAIN_W:0]    trial;
    o = in;
    for (int i = MVQ_W - 1; i >= 0; i--) begin
      if (i <= hi && i >= lo) begin
        trial = {o.rem, o.num[i]};
        if (trial >= {1'b0, o.g}) begin
          o.rem    = GAIN_W'(trial - {1'b0, o.g});
          o.quo[i] = 1'b1;
        end else begin
          o.rem = trial[GAIN_W-1:0];
        end
      end
    end
    return o;
  endfunction

  // Value of the channels that need no gain division.
  function automatic logic signed [OUT_W-1:0] side_value(logic [CH_W-1:0] ch,
                                                       logic signed [RAW_W-1:0] raw,
                                                       logic [MAG_W-1:0] mag,
                                                       logic neg);
    logic [10:0]      third;
    logic [OUT_W-1:0] m;
    logic [OUT_W-1:0] r;
    third = 11'(mag[MAG_W-1:SUPPLY_SHIFT]) * 11'(THIRD_MUL);
    m = '0;
    case (ch) inside
      CH_SUPPLY, CH_REF: m = OUT_W'(third[10:THIRD_SHIFT]);
      CH_GAIN:           m = (mag >= MAG_W'(GAIN_DIV)) ? OUT_W'(1) : '0;
      default:           m = '0;
    endcase
    r = neg ? OUT_W'(-m) : m;
    if (ch == CH_RAW) begin
      r = raw;
    end
    return $signed(r);
  endfunction

endpackage

FILE: sv/adc_channel_converter_top.sv
// ADC channel converter: raw sample and channel in, converted value out.
// Depends on acc_pkg and assert_macros.svh.
//
//  port group  direction  tdata                  tuser
//  s_axis      in         raw_sample[15:0]       channel[4:0]
//  m_axis      out        converted_value[15:0]  channel_out[4:0], bad_channel[5]
//  cfg         in         amp_gain[6:0]          -
//
// Ten register stages, one beat per cycle while m_axis_tready holds; the pipeline
// depth is set by the three-stage gain divider and the temperature reciprocal path.
// Reset clears all stage valid bits and loads gain 1.
// A stall holds only the stages behind a full one; empty stages keep filling.
// Gain writes take effect for beats accepted after the write.
`include "assert_macros.svh"

module adc_channel_converter_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic signed [acc_pkg::RAW_W-1:0] s_axis_tdata,  // [15:0] raw_sample
  input  logic [acc_pkg::CH_W-1:0]     s_axis_tuser,      // [4:0] channel
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic signed [acc_pkg::OUT_W-1:0] m_axis_tdata,  // [15:0] converted_value
  output logic [acc_pkg::CH_W:0]       m_axis_tuser,      // [4:0] channel_out, [5] bad_channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [acc_pkg::GAIN_W-1:0]   cfg_data_i         // [6:0] amp_gain
);

  logic [acc_pkg::NSTG-1:0] v_q, v_d, en;
  logic [acc_pkg::GAIN_W-1:0] gain_q, g_eff;

  // Stage A
  logic [acc_pkg::CH_W-1:0]         a_ch_q;
  logic signed [acc_pkg::RAW_W-1:0] a_raw_q;
  logic [acc_pkg::GAIN_W-1:0]       a_g_q;

  // Stage B
  logic                              b_neg;
  logic [acc_pkg::MAG_W-1:0]         b_mag;
  logic [acc_pkg::CH_W-1:0]          b_ch_q;
  logic                              b_neg_q;
  logic [acc_pkg::PROD_W-1:0]        b_prod_q;
  logic signed [acc_pkg::OUT_W-1:0]  b_side_q;
  logic [acc_pkg::GAIN_W-1:0]        b_g_q;

  // Stages C, D, E: gain divider
  acc_pkg::div_stage_t dv_in;
  acc_pkg::div_stage_t dv_d [acc_pkg::NDIV];
  acc_pkg::div_stage_t dv_q [acc_pkg::NDIV];

  // Stage F
  logic signed [acc_pkg::MV_W-1:0]   f_mv_d, f_mv_q;
  logic [acc_pkg::CH_W-1:0]          f_ch_q;
  logic signed [acc_pkg::OUT_W-1:0]  f_side_q;

  // Stage G
  logic signed [acc_pkg::TN_W-1:0]   g_tn, g_tabs;
  logic                              g_tneg_q;
  logic [acc_pkg::TMAG_W-1:0]        g_tmag_q;
  logic signed [acc_pkg::MV_W-1:0]   g_mv_q;
  logic [acc_pkg::CH_W-1:0]          g_ch_q;
  logic signed [acc_pkg::OUT_W-1:0]  g_side_q;

  // Stage H
  logic [acc_pkg::TPROD_W-1:0]       h_prod_q;
  logic                              h_tneg_q;
  logic [acc_pkg::TMAG_W-1:0]        h_tmag_q;
  logic signed [acc_pkg::MV_W-1:0]   h_mv_q;
  logic [acc_pkg::CH_W-1:0]          h_ch_q;
  logic signed [acc_pkg::OUT_W-1:0]  h_side_q;

  // Stage I
  logic [acc_pkg::TQ_W-1:0]          i_q0, i_quo;
  logic [acc_pkg::TMAG_W:0]          i_rem;
  logic signed [acc_pkg::TEMP_W-1:0] i_temp_d, i_temp_q;
  logic signed [acc_pkg::MV_W-1:0]   i_mv_q;
  logic [acc_pkg::CH_W-1:0]          i_ch_q;
  logic signed [acc_pkg::OUT_W-1:0]  i_side_q;

  // Output stage
  logic signed [acc_pkg::OUT_W-1:0]  o_val_d, o_val_q;
  logic                              o_bad_d, o_bad_q;
  logic [acc_pkg::CH_W-1:0]          o_ch_q;

  // ---------------------------------------------------------------- config
  assign cfg_ready_o = 1'b1;
  assign g_eff = (gain_q == '0) ? acc_pkg::GAIN_RESET : gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= acc_pkg::GAIN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      gain_q <= cfg_data_i;
    end
  end

  // ---------------------------------------------------------------- flow control
  // A stage advances when it is empty or the stage after it advances.
  always_comb begin
    en[acc_pkg::NSTG-1] = !v_q[acc_pkg::NSTG-1] || m_axis_tready;
    for (int k = acc_pkg::NSTG - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d[0] = en[0] ? s_axis_tvalid : v_q[0];
    for (int k = 1; k < acc_pkg::NSTG; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign s_axis_tready = en[acc_pkg::STG_A];

  // ---------------------------------------------------------------- stage A
  always_ff @(posedge clk_i) begin
    if (en[acc_pkg::STG_A]) begin
      a_ch_q  <= s_axis_tuser;
      a_raw_q <= s_axis_tdata;
      a_g_q   <= g_eff;
    end
  end

  // ---------------------------------------------------------------- stage B
  assign b_neg = a_raw_q[acc_pkg::RAW_W-1];
  assign b_mag = b_neg ? acc_pkg::MAG_W'(-a_raw_q) : acc_pkg::MAG_W'(a_raw_q);

  always_ff @(posedge clk_i) begin
    if (en[acc_pkg::STG_B]) begin
      b_ch_q   <= a_ch_q;
      b_neg_q  <= b_neg;
      b_prod_q <= acc_pkg::PROD_W'(b_mag) * acc_pkg::PROD_W'(acc_pkg::MV_RANGE);
      b_side_q <= acc_pkg::side_value(a_ch_q, a_raw_q, b_mag, b_neg);
      b_g_q    <= a_g_q;
    end
  end

  // ---------------------------------------------------------------- stages C..E
  // Divide the full-scale-scaled product by the gain, five then four then four bits.
  always_comb begin
    dv_in.ch   = b_ch_q;
    dv_in.neg  = b_neg_q;
    dv_in.side = b_side_q;
    dv_in.g    = b_g_q;
    dv_in.num  = b_prod_q[acc_pkg::PROD_W-1:acc_pkg::MV_SHIFT];
    dv_in.quo  = '0;
    dv_in.rem  = '0;
    dv_d[0] = acc_pkg::div_bits(dv_in, 12, 8);
    dv_d[1] = acc_pkg::div_bits(dv_q[0], 7, 4);
    dv_d[2] = acc_pkg::div_bits(dv_q[1], 3, 0);
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < acc_pkg::NDIV; s++) begin
      if (en[acc_pkg::STG_C + s]) begin
        dv_q[s] <= dv_d[s];
      end
    end
  end

  // ---------------------------------------------------------------- stage F
  always_comb begin
    f_mv_d = $signed({1'b0, dv_q[acc_pkg::NDIV-1].quo});
    if (dv_q[acc_pkg::NDIV-1].neg) begin
      f_mv_d = -f_mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[acc_pkg::STG_F]) begin
      f_mv_q   <= f_mv_d;
      f_ch_q   <= dv_q[acc_pkg::NDIV-1].ch;
      f_side_q <= dv_q[acc_pkg::NDIV-1].side;
    end
  end

  // ---------------------------------------------------------------- stage G
  assign g_tn = acc_pkg::TN_W'(f_mv_q) * acc_pkg::TN_W'(acc_pkg::TEMP_SCALE)
              - acc_pkg::TN_W'(acc_pkg::TEMP_OFFSET);
  assign g_tabs = g_tn[acc_pkg::TN_W-1] ? -g_tn : g_tn;

  always_ff @(posedge clk_i) begin
    if (en[acc_pkg::STG_G]) begin
      g_tneg_q <= g_tn[acc_pkg::TN_W-1];
      g_tmag_q <= g_tabs[acc_pkg::TMAG_W-1:0];
      g_mv_q   <= f_mv_q;
      g_ch_q   <= f_ch_q;
      g_side_q <= f_side_q;
    end
  end

  // ---------------------------------------------------------------- stage H
  always_ff @(posedge clk_i) begin
    if (en[acc_pkg::STG_H]) begin
      h_prod_q <= acc_pkg::TPROD_W'(g_tmag_q) * acc_pkg::TPROD_W'(acc_pkg::TEMP_RECIP);
      h_tneg_q <= g_tneg_q;
      h_tmag_q <= g_tmag_q;
      h_mv_q   <= g_mv_q;
      h_ch_q   <= g_ch_q;
      h_side_q <= g_side_q;
    end
  end

  // ---------------------------------------------------------------- stage I
  // Reciprocal estimate is exact or one low; fix with one compare.
  always_comb begin
    i_q0  = h_prod_q[acc_pkg::RECIP_SHIFT +: acc_pkg::TQ_W];
    i_rem = (acc_pkg::TMAG_W + 1)'(h_tmag_q)
          - (acc_pkg::TMAG_W + 1)'(i_q0) * (acc_pkg::TMAG_W + 1)'(acc_pkg::TEMP_SLOPE);
    i_quo = (i_rem >= (acc_pkg::TMAG_W + 1)'(acc_pkg::TEMP_SLOPE)) ? i_q0 + 1'b1 : i_q0;
    i_temp_d = $signed({1'b0, i_quo});
    if (h_tneg_q) begin
      i_temp_d = -i_temp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[acc_pkg::STG_I]) begin
      i_temp_q <= i_temp_d;
      i_mv_q   <= h_mv_q;
      i_ch_q   <= h_ch_q;
      i_side_q <= h_side_q;
    end
  end

  // ---------------------------------------------------------------- output stage
  always_comb begin
    o_bad_d = 1'b0;
    unique case (i_ch_q) inside
      [acc_pkg::CH_MV_FIRST:acc_pkg::CH_MV_LAST]: o_val_d = acc_pkg::OUT_W'(i_mv_q);
      acc_pkg::CH_TEMP:                           o_val_d = acc_pkg::OUT_W'(i_temp_q);
      acc_pkg::CH_RAW, acc_pkg::CH_SUPPLY,
      acc_pkg::CH_GAIN, acc_pkg::CH_REF:          o_val_d = i_side_q;
      default: begin
        o_val_d = '0;
        o_bad_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[acc_pkg::STG_O]) begin
      o_val_q <= o_val_d;
      o_bad_q <= o_bad_d;
      o_ch_q  <= i_ch_q;
    end
  end

  assign m_axis_tvalid = v_q[acc_pkg::STG_O];
  assign m_axis_tdata  = o_val_q;
  assign m_axis_tuser  = {o_bad_q, o_ch_q};

  // ---------------------------------------------------------------- assertions
  `ACC_ASSERT_NORST(a_rst_empty, clk_i, !rst_ni |=> v_q == '0)
  `ACC_ASSERT(a_div_rem, clk_i, rst_ni, v_q[acc_pkg::STG_E] |-> dv_q[acc_pkg::NDIV-1].rem < dv_q[acc_pkg::NDIV-1].g)
  `ACC_ASSERT(a_temp_est, clk_i, rst_ni, v_q[acc_pkg::STG_H] |-> i_rem < (acc_pkg::TMAG_W + 1)'(2 * acc_pkg::TEMP_SLOPE))
  `ACC_ASSERT(a_bad_flag, clk_i, rst_ni, m_axis_tvalid |-> m_axis_tuser[acc_pkg::CH_W] == (m_axis_tuser[acc_pkg::CH_W-1:0] > acc_pkg::CH_REF))
  `ACC_ASSERT(a_bad_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[acc_pkg::CH_W] |-> m_axis_tdata == '0)

endmodule
